FILE: rtl/topo_pkg.sv
// Shared types and constants for the topological order block.
`timescale 1ns / 1ps

package topo_pkg;

  localparam int NODE_W        = 6;
  localparam int CNT_W         = 7;
  localparam int DEF_MAX_NODES = 64;
  localparam int NODE_CAP      = 64;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic STATUS_ORDER = 1'b0;
  localparam logic STATUS_CYCLE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEG,
    S_SEED,
    S_POPQ,
    S_POPA,
    S_CHECK,
    S_EMIT,
    S_EMLD
  } topo_state_t;

endpackage

FILE: rtl/topo_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module topo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic             re,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign rd = rd_r;

endmodule

FILE: rtl/topological_order_kahn.sv
// Top level of the topological order block: pair loading, Kahn sweep and order or cycle-status output.
`timescale 1ns / 1ps

// Dependency pairs load at one request per cycle while idle into an adjacency row memory;
// a read and write-back of the same row in consecutive cycles is covered by forwarding. A
// compute request builds the in-degree counters from one row read per cycle, then for each
// node queues it and pops it by a queue read, a row read and a counter update, then closes
// the sweep and checks it, and then emits the order results from the queue while the sink
// is ready, or a single cycle-status result if not every node in use was ordered.
// The queue memory doubles as the order list. The store is cleared by per-row valid
// bits, so no clearing pass is needed.

module topological_order_kahn #(
  parameter int MAX_NODES = topo_pkg::DEF_MAX_NODES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [topo_pkg::CNT_W-1:0]  cfg_node_count,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [topo_pkg::NODE_W-1:0] in_dependent_node,
  input  logic [topo_pkg::NODE_W-1:0] in_required_node,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [topo_pkg::NODE_W-1:0] out_node_index,
  output logic                        out_status,
  output logic                        out_is_last
);

  import topo_pkg::*;

  localparam int STORE_N = (MAX_NODES < NODE_CAP) ? MAX_NODES : NODE_CAP;
  localparam int ROW_W   = $clog2(STORE_N);
  localparam logic [CNT_W-1:0] NODE_LIM = CNT_W'(STORE_N);

  topo_state_t state_r, state_nxt;

  logic [CNT_W-1:0]   node_count_r;
  logic [CNT_W-1:0]   n_use;
  logic [STORE_N-1:0] col_mask;

  logic               add_v_r, add_v_nxt;
  logic [ROW_W-1:0]   add_row_r, add_row_nxt;
  logic [ROW_W-1:0]   add_col_r, add_col_nxt;
  logic               fwd_v_r, fwd_v_nxt;
  logic [ROW_W-1:0]   fwd_row_r, fwd_row_nxt;
  logic [STORE_N-1:0] fwd_data_r, fwd_data_nxt;
  logic [STORE_N-1:0] row_valid_r, row_valid_nxt;
  logic [ROW_W-1:0]   adj_row_r, adj_row_nxt;
  logic               rdv_r, rdv_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   tail_r, tail_nxt;
  logic [STORE_N-1:0] pend_r, pend_nxt;
  logic [CNT_W-1:0]   deg_r [STORE_N];
  logic [CNT_W-1:0]   deg_nxt [STORE_N];

  logic               out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]  out_node_r, out_node_nxt;
  logic               out_status_r, out_status_nxt;
  logic               out_last_r, out_last_nxt;

  logic               adj_we, adj_re;
  logic [ROW_W-1:0]   adj_wa, adj_ra;
  logic [STORE_N-1:0] adj_wd, adj_rd;
  logic               q_we, q_re;
  logic [ROW_W-1:0]   q_wa, q_ra;
  logic [NODE_W-1:0]  q_wd, q_rd;

  logic [STORE_N-1:0] adj_rows, row_bits, add_base;
  logic [ROW_W-1:0]   pick;
  logic               slot_free;
  logic               pair_ok;

  topo_ram #(.WIDTH(STORE_N), .DEPTH(STORE_N)) u_adj (
    .clk (clk),
    .we  (adj_we),
    .wa  (adj_wa),
    .wd  (adj_wd),
    .re  (adj_re),
    .ra  (adj_ra),
    .rd  (adj_rd)
  );

  topo_ram #(.WIDTH(NODE_W), .DEPTH(STORE_N)) u_queue (
    .clk (clk),
    .we  (q_we),
    .wa  (q_wa),
    .wd  (q_wd),
    .re  (q_re),
    .ra  (q_ra),
    .rd  (q_rd)
  );

  always_comb begin
    if (node_count_r == '0) begin
      n_use = CNT_W'(1);
    end else if (node_count_r > NODE_LIM) begin
      n_use = NODE_LIM;
    end else begin
      n_use = node_count_r;
    end
    for (int j = 0; j < STORE_N; j++) begin
      col_mask[j] = (CNT_W'(j) < n_use);
    end
  end

  always_comb begin
    pick = '0;
    for (int j = STORE_N - 1; j >= 0; j--) begin
      if (pend_r[j]) begin
        pick = ROW_W'(j);
      end
    end
  end

  assign adj_rows  = row_valid_r[adj_row_r] ? adj_rd : '0;
  assign row_bits  = adj_rows & col_mask;
  assign add_base  = (fwd_v_r && fwd_row_r == add_row_r) ? fwd_data_r : adj_rows;
  assign slot_free = !out_valid_r || out_ready;
  assign pair_ok   = ({1'b0, in_dependent_node} < NODE_LIM) &&
                     ({1'b0, in_required_node} < NODE_LIM);

  always_comb begin
    state_nxt      = state_r;
    add_v_nxt      = 1'b0;
    add_row_nxt    = add_row_r;
    add_col_nxt    = add_col_r;
    fwd_v_nxt      = 1'b0;
    fwd_row_nxt    = fwd_row_r;
    fwd_data_nxt   = fwd_data_r;
    row_valid_nxt  = row_valid_r;
    adj_row_nxt    = adj_row_r;
    rdv_nxt        = rdv_r;
    cnt_nxt        = cnt_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    pend_nxt       = pend_r;
    deg_nxt        = deg_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_node_nxt   = out_node_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    adj_we         = 1'b0;
    adj_wa         = add_row_r;
    adj_wd         = add_base | (STORE_N'(1) << add_col_r);
    adj_re         = 1'b0;
    adj_ra         = '0;
    q_we           = 1'b0;
    q_wa           = tail_r[ROW_W-1:0];
    q_wd           = NODE_W'(pick);
    q_re           = 1'b0;
    q_ra           = '0;
    in_ready       = 1'b0;

    if (add_v_r) begin
      adj_we                   = 1'b1;
      row_valid_nxt[add_row_r] = 1'b1;
      fwd_v_nxt                = 1'b1;
      fwd_row_nxt              = add_row_r;
      fwd_data_nxt             = adj_wd;
    end

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_ADD) begin
            if (pair_ok) begin
              add_v_nxt   = 1'b1;
              add_row_nxt = in_dependent_node[ROW_W-1:0];
              add_col_nxt = in_required_node[ROW_W-1:0];
              adj_re      = 1'b1;
              adj_ra      = in_dependent_node[ROW_W-1:0];
              adj_row_nxt = in_dependent_node[ROW_W-1:0];
            end
          end else begin
            cnt_nxt = '0;
            rdv_nxt = 1'b0;
            for (int j = 0; j < STORE_N; j++) begin
              deg_nxt[j] = '0;
            end
            state_nxt = S_DEG;
          end
        end
      end
      S_DEG: begin
        rdv_nxt = 1'b0;
        if (cnt_r < n_use) begin
          adj_re      = 1'b1;
          adj_ra      = cnt_r[ROW_W-1:0];
          adj_row_nxt = cnt_r[ROW_W-1:0];
          cnt_nxt     = cnt_r + CNT_W'(1);
          rdv_nxt     = 1'b1;
        end
        if (rdv_r) begin
          for (int j = 0; j < STORE_N; j++) begin
            deg_nxt[j] = deg_r[j] + CNT_W'(row_bits[j]);
          end
        end
        if (cnt_r == n_use && !rdv_r) begin
          for (int j = 0; j < STORE_N; j++) begin
            pend_nxt[j] = col_mask[j] && (deg_r[j] == '0);
          end
          head_nxt  = '0;
          tail_nxt  = '0;
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        if (pend_r != '0) begin
          q_we           = 1'b1;
          pend_nxt[pick] = 1'b0;
          tail_nxt       = tail_r + CNT_W'(1);
        end else if (head_r != tail_r) begin
          q_re      = 1'b1;
          q_ra      = head_r[ROW_W-1:0];
          head_nxt  = head_r + CNT_W'(1);
          state_nxt = S_POPQ;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_POPQ: begin
        adj_re      = 1'b1;
        adj_ra      = q_rd[ROW_W-1:0];
        adj_row_nxt = q_rd[ROW_W-1:0];
        state_nxt   = S_POPA;
      end
      S_POPA: begin
        for (int j = 0; j < STORE_N; j++) begin
          if (row_bits[j] && deg_r[j] != '0) begin
            deg_nxt[j] = deg_r[j] - CNT_W'(1);
            if (deg_r[j] == CNT_W'(1)) begin
              pend_nxt[j] = 1'b1;
            end
          end
        end
        state_nxt = S_SEED;
      end
      S_CHECK: begin
        if (tail_r != n_use) begin
          if (slot_free) begin
            out_valid_nxt  = 1'b1;
            out_node_nxt   = '0;
            out_status_nxt = STATUS_CYCLE;
            out_last_nxt   = 1'b1;
            row_valid_nxt  = '0;
            head_nxt       = '0;
            tail_nxt       = '0;
            for (int j = 0; j < STORE_N; j++) begin
              deg_nxt[j] = '0;
            end
            state_nxt = S_IDLE;
          end
        end else begin
          cnt_nxt   = tail_r - CNT_W'(1);
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        q_re      = 1'b1;
        q_ra      = cnt_r[ROW_W-1:0];
        state_nxt = S_EMLD;
      end
      S_EMLD: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_node_nxt   = q_rd;
          out_status_nxt = STATUS_ORDER;
          out_last_nxt   = (cnt_r == '0);
          if (cnt_r == '0) begin
            row_valid_nxt = '0;
            head_nxt      = '0;
            tail_nxt      = '0;
            for (int j = 0; j < STORE_N; j++) begin
              deg_nxt[j] = '0;
            end
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r - CNT_W'(1);
            state_nxt = S_EMIT;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= NODE_COUNT_RST;
      add_v_r      <= 1'b0;
      fwd_v_r      <= 1'b0;
      row_valid_r  <= '0;
      rdv_r        <= 1'b0;
      cnt_r        <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      pend_r       <= '0;
      out_valid_r  <= 1'b0;
      for (int j = 0; j < STORE_N; j++) begin
        deg_r[j] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid) begin
        node_count_r <= cfg_node_count;
      end
      add_v_r     <= add_v_nxt;
      fwd_v_r     <= fwd_v_nxt;
      row_valid_r <= row_valid_nxt;
      rdv_r       <= rdv_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      deg_r       <= deg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    add_row_r    <= add_row_nxt;
    add_col_r    <= add_col_nxt;
    fwd_row_r    <= fwd_row_nxt;
    fwd_data_r   <= fwd_data_nxt;
    adj_row_r    <= adj_row_nxt;
    out_node_r   <= out_node_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_node_index = out_node_r;
  assign out_status     = out_status_r;
  assign out_is_last    = out_last_r;

  a_cycle_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_CYCLE |-> out_is_last && out_node_index == '0)
    else $error("cycle result must be the last result and carry node index zero");

  a_queue_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> tail_r <= n_use && head_r <= tail_r)
    else $error("ready queue pointers out of range");

  a_add_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    add_v_r |-> $past(state_r) == S_IDLE)
    else $error("row write-back without a pair request in idle");

endmodule
